// ----- design/mnc_pkg.sv -----
// ---------------------------------------------------------------------------
// mnc_pkg: shared types and constants
// Sizes, function and status codes, vector types for the mesh normal block.
// ---------------------------------------------------------------------------
package mnc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_FACES    = 2048;
   localparam int VERT_AW      = $clog2(MAX_VERTICES);
   localparam int FACE_AW      = $clog2(MAX_FACES);

   localparam int COORD_W = 16;
   localparam int NORM_W  = 16;
   localparam int WIDE_W  = 36;
   localparam int SUM_W   = 32;

   localparam logic [2:0] FUNC_LOAD_VERT = 3'd0;
   localparam logic [2:0] FUNC_LOAD_FACE = 3'd1;
   localparam logic [2:0] FUNC_COMPUTE   = 3'd2;
   localparam logic [2:0] FUNC_READ_FACE = 3'd3;
   localparam logic [2:0] FUNC_READ_VERT = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_INDEX  = 2'd1;
   localparam logic [1:0] STATUS_CORNER = 2'd2;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_FACE_COUNT   = 1'b1;

   typedef struct packed {
      logic signed [WIDE_W-1:0] x;
      logic signed [WIDE_W-1:0] y;
      logic signed [WIDE_W-1:0] z;
   } wide_vec_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
   } norm_vec_type;

endpackage

// ----- design/mnc_norm.sv -----
// ---------------------------------------------------------------------------
// mnc_norm: iterative vector normalizer
// Scales a vector down below 2^24, takes an integer square root bit by bit
// and divides each component by it, giving a Q1.14 unit vector.
// ---------------------------------------------------------------------------
module mnc_norm import mnc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  wide_vec_type vec,
   output logic         done,
   output norm_vec_type result
);

   typedef enum logic [5:0] {
      N_IDLE  = 6'b000001,
      N_SHIFT = 6'b000010,
      N_SQ    = 6'b000100,
      N_SQRT  = 6'b001000,
      N_DINIT = 6'b010000,
      N_DIV   = 6'b100000
   } nstate_type;

   nstate_type nstate_ff, nstate_in;
   logic [WIDE_W-1:0]        mag_ff [3];
   logic [WIDE_W-1:0]        mag_in [3];
   logic                     neg_ff [3];
   logic                     neg_in [3];
   logic [49:0]              sum_ff, sum_in;
   logic [24:0]              root_ff, root_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic [1:0]               j_ff, j_in;
   logic [38:0]              rem_ff, rem_in;
   logic [14:0]              q_ff, q_in;
   logic signed [NORM_W-1:0] res_ff [3];
   logic signed [NORM_W-1:0] res_in [3];
   logic                     done_ff, done_in;

   logic [WIDE_W-1:0] mx;
   logic [23:0]       sq_op;
   logic [47:0]       sq;
   logic [24:0]       cand;
   logic [49:0]       csq;
   logic [38:0]       dv;
   logic signed [WIDE_W-1:0] vin [3];

   assign vin[0] = vec.x;
   assign vin[1] = vec.y;
   assign vin[2] = vec.z;

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      sq_op = mag_ff[j_ff][23:0];
      sq    = sq_op * sq_op;
      cand  = root_ff | (25'd1 << cnt_ff);
      csq   = cand * cand;
      dv    = 39'(root_ff) << cnt_ff;
   end

   always_comb begin
      nstate_in = nstate_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      sum_in    = sum_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      j_in      = j_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      case (nstate_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vin[i] < 0;
                  mag_in[i] = (vin[i] < 0) ? WIDE_W'(-vin[i]) : WIDE_W'(vin[i]);
               end
               nstate_in = N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (mx == '0) begin
               for (int i = 0; i < 3; i++) res_in[i] = '0;
               done_in   = 1'b1;
               nstate_in = N_IDLE;
            end else if (mx[WIDE_W-1:24] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else begin
               j_in      = 2'd0;
               sum_in    = '0;
               nstate_in = N_SQ;
            end
         end
         N_SQ: begin
            sum_in = sum_ff + 50'(sq);
            if (j_ff == 2'd2) begin
               root_in   = '0;
               cnt_in    = 5'd24;
               nstate_in = N_SQRT;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         N_SQRT: begin
            if (csq <= sum_ff) root_in = cand;
            if (cnt_ff == 5'd0) begin
               j_in      = 2'd0;
               nstate_in = N_DINIT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         N_DINIT: begin
            rem_in    = {1'b0, mag_ff[j_ff][23:0], 14'b0} + 39'(root_ff >> 1);
            q_in      = '0;
            cnt_in    = 5'd14;
            nstate_in = N_DIV;
         end
         N_DIV: begin
            if (rem_ff >= dv) begin
               rem_in           = rem_ff - dv;
               q_in[cnt_ff[3:0]] = 1'b1;
            end
            if (cnt_ff == 5'd0) begin
               res_in[j_ff] = neg_ff[j_ff] ? -$signed({1'b0, q_in})
                                           : $signed({1'b0, q_in});
               if (j_ff == 2'd2) begin
                  done_in   = 1'b1;
                  nstate_in = N_IDLE;
               end else begin
                  j_in      = j_ff + 2'd1;
                  nstate_in = N_DINIT;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         default: nstate_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nstate_ff <= N_IDLE;
         done_ff   <= 1'b0;
      end else begin
         nstate_ff <= nstate_in;
         done_ff   <= done_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      j_ff    <= j_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

   assign done     = done_ff;
   assign result.x = res_ff[0];
   assign result.y = res_ff[1];
   assign result.z = res_ff[2];

endmodule

// ----- design/mesh_normal_calculator.sv -----
// ---------------------------------------------------------------------------
// mesh_normal_calculator: face-averaged vertex normals
// Stores vertices and faces, computes face normals by cross product and
// accumulates them into per-vertex sums that are normalized when read.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   func, index, position, corners
//   rsp       out        rsp_valid/rsp_ready   normal xyz, status
//   csr       in         csr_we                index, write data
//
// loads, out-of-range items and reads while results are not valid answer in
// the cycle after the beat; a face read answers through the memory read
// register and S_F_RD. a vertex read runs in the shared normalizer (shift,
// square root, three divides). compute runs a face pass (cross product and
// normalize per face), a pass that clears the vertex sums and a sum pass. no
// clearing pass after reset. req_ready is low while busy or while a response beat waits.
// ---------------------------------------------------------------------------
module mesh_normal_calculator import mnc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_func,
   input  logic [10:0]               req_item_index,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic [9:0]                req_corner_a,
   input  logic [9:0]                req_corner_b,
   input  logic [9:0]                req_corner_c,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [NORM_W-1:0]  rsp_norm_x,
   output logic signed [NORM_W-1:0]  rsp_norm_y,
   output logic signed [NORM_W-1:0]  rsp_norm_z,
   output logic [1:0]                rsp_status,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [11:0]               csr_wdata
);

   typedef enum logic [17:0] {
      S_IDLE    = 18'h00001,
      S_F_RD    = 18'h00002,
      S_V_RD    = 18'h00004,
      S_V_NORM  = 18'h00008,
      S_C_CORN  = 18'h00010,
      S_C_CHK   = 18'h00020,
      S_C_VA    = 18'h00040,
      S_C_VB    = 18'h00080,
      S_C_VC    = 18'h00100,
      S_C_CROSS = 18'h00200,
      S_C_START = 18'h00400,
      S_C_NORM  = 18'h00800,
      S_CLR     = 18'h01000,
      S_A_CORN  = 18'h02000,
      S_A_CHK   = 18'h04000,
      S_A_FN    = 18'h08000,
      S_A_RD    = 18'h10000,
      S_A_RMW   = 18'h20000
   } state_type;

   // memories
   logic [47:0] vpos_mem  [MAX_VERTICES];
   logic [29:0] fcorn_mem [MAX_FACES];
   logic [47:0] fnorm_mem [MAX_FACES];
   logic [95:0] vsum_mem  [MAX_VERTICES];

   logic               vpos_we, fcorn_we, fnorm_we, vsum_we;
   logic [VERT_AW-1:0] vpos_waddr, vpos_raddr, vsum_waddr, vsum_raddr;
   logic [FACE_AW-1:0] fcorn_waddr, fcorn_raddr, fnorm_waddr, fnorm_raddr;
   logic [47:0]        vpos_wdata, fnorm_wdata;
   logic [29:0]        fcorn_wdata;
   logic [95:0]        vsum_wdata;
   logic [47:0]        vpos_rd_ff, fnorm_rd_ff;
   logic [29:0]        fcorn_rd_ff;
   logic [95:0]        vsum_rd_ff;

   always_ff @(posedge clock) begin
      if (vpos_we) vpos_mem[vpos_waddr] <= vpos_wdata;
      vpos_rd_ff <= vpos_mem[vpos_raddr];
   end
   always_ff @(posedge clock) begin
      if (fcorn_we) fcorn_mem[fcorn_waddr] <= fcorn_wdata;
      fcorn_rd_ff <= fcorn_mem[fcorn_raddr];
   end
   always_ff @(posedge clock) begin
      if (fnorm_we) fnorm_mem[fnorm_waddr] <= fnorm_wdata;
      fnorm_rd_ff <= fnorm_mem[fnorm_raddr];
   end
   always_ff @(posedge clock) begin
      if (vsum_we) vsum_mem[vsum_waddr] <= vsum_wdata;
      vsum_rd_ff <= vsum_mem[vsum_raddr];
   end

   // control and datapath registers
   state_type state_ff, state_in;
   logic [10:0]  vcount_ff, vcount_in;
   logic [11:0]  fcount_ff, fcount_in;
   logic         valid_ff, valid_in;
   logic         bad_ff, bad_in;
   logic [11:0]  f_ff, f_in;
   logic [10:0]  v_ff, v_in;
   logic [1:0]   k_ff, k_in;
   logic [2:0]   step_ff, step_in;
   logic [47:0]  pa_ff, pa_in;
   logic signed [16:0] e1_ff [3];
   logic signed [16:0] e1_in [3];
   logic signed [16:0] e2_ff [3];
   logic signed [16:0] e2_in [3];
   logic signed [33:0] acc_ff, acc_in;
   logic signed [34:0] cr_ff [3];
   logic signed [34:0] cr_in [3];
   logic [9:0]   cn_ff [3];
   logic [9:0]   cn_in [3];
   logic [47:0]  fn_ff, fn_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic signed [NORM_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [1:0]   rsp_st_ff, rsp_st_in;

   logic [10:0]  nv;
   logic [11:0]  nf;
   logic         accept;
   logic         norm_start, norm_done;
   wide_vec_type norm_vec;
   norm_vec_type norm_res;
   logic signed [16:0] opa, opb;
   logic signed [33:0] prod;
   logic [9:0]   ca, cb, cc;
   logic         corner_bad;
   logic signed [COORD_W-1:0] fnv [3];
   logic signed [SUM_W-1:0]   sumv [3];
   logic signed [SUM_W-1:0]   sumw [3];
   logic signed [SUM_W:0]     s33 [3];
   logic signed [COORD_W-1:0] pos [3];
   logic signed [COORD_W-1:0] pav [3];

   mnc_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .vec    (norm_vec),
      .done   (norm_done),
      .result (norm_res)
   );

   assign nv = (vcount_ff > 11'(MAX_VERTICES)) ? 11'(MAX_VERTICES) : vcount_ff;
   assign nf = (fcount_ff > 12'(MAX_FACES)) ? 12'(MAX_FACES) : fcount_ff;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign ca = fcorn_rd_ff[29:20];
   assign cb = fcorn_rd_ff[19:10];
   assign cc = fcorn_rd_ff[9:0];
   assign corner_bad = ({1'b0, ca} >= nv) || ({1'b0, cb} >= nv) || ({1'b0, cc} >= nv);

   assign pos[0] = vpos_rd_ff[47:32];
   assign pos[1] = vpos_rd_ff[31:16];
   assign pos[2] = vpos_rd_ff[15:0];
   assign pav[0] = pa_ff[47:32];
   assign pav[1] = pa_ff[31:16];
   assign pav[2] = pa_ff[15:0];
   assign fnv[0] = fn_ff[47:32];
   assign fnv[1] = fn_ff[31:16];
   assign fnv[2] = fn_ff[15:0];
   assign sumv[0] = vsum_rd_ff[95:64];
   assign sumv[1] = vsum_rd_ff[63:32];
   assign sumv[2] = vsum_rd_ff[31:0];

   // saturating accumulate of a face normal into a vertex sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s33[i] = {sumv[i][SUM_W-1], sumv[i]} + (SUM_W+1)'(fnv[i]);
         if (s33[i][SUM_W] != s33[i][SUM_W-1])
            sumw[i] = s33[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
         else
            sumw[i] = s33[i][SUM_W-1:0];
      end
   end

   // cross product operand select, one product per step
   always_comb begin
      case (step_ff)
         3'd0: begin opa = e1_ff[1]; opb = e2_ff[2]; end
         3'd1: begin opa = e1_ff[2]; opb = e2_ff[1]; end
         3'd2: begin opa = e1_ff[2]; opb = e2_ff[0]; end
         3'd3: begin opa = e1_ff[0]; opb = e2_ff[2]; end
         3'd4: begin opa = e1_ff[0]; opb = e2_ff[1]; end
         3'd5: begin opa = e1_ff[1]; opb = e2_ff[0]; end
         default: begin opa = '0; opb = '0; end
      endcase
      prod = opa * opb;
   end

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      fcount_in    = fcount_ff;
      valid_in     = valid_ff;
      bad_in       = bad_ff;
      f_in         = f_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      pa_in        = pa_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      acc_in       = acc_ff;
      cr_in        = cr_ff;
      cn_in        = cn_ff;
      fn_in        = fn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_st_in    = rsp_st_ff;

      vpos_we     = 1'b0;
      vpos_waddr  = req_item_index[VERT_AW-1:0];
      vpos_wdata  = {req_pos_x, req_pos_y, req_pos_z};
      vpos_raddr  = ca;
      fcorn_we    = 1'b0;
      fcorn_waddr = req_item_index[FACE_AW-1:0];
      fcorn_wdata = {req_corner_a, req_corner_b, req_corner_c};
      fcorn_raddr = f_ff[FACE_AW-1:0];
      fnorm_we    = 1'b0;
      fnorm_waddr = f_ff[FACE_AW-1:0];
      fnorm_wdata = norm_res;
      fnorm_raddr = f_ff[FACE_AW-1:0];
      vsum_we     = 1'b0;
      vsum_waddr  = cn_ff[k_ff];
      vsum_wdata  = {sumw[0], sumw[1], sumw[2]};
      vsum_raddr  = cn_ff[k_ff];

      norm_start = 1'b0;
      norm_vec.x = WIDE_W'(cr_ff[0]);
      norm_vec.y = WIDE_W'(cr_ff[1]);
      norm_vec.z = WIDE_W'(cr_ff[2]);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_z_in     = '0;
               rsp_st_in    = STATUS_OK;
               case (req_func)
                  FUNC_LOAD_VERT: begin
                     if (req_item_index >= nv) begin
                        rsp_st_in = STATUS_INDEX;
                     end else begin
                        vpos_we  = 1'b1;
                        valid_in = 1'b0;
                     end
                  end
                  FUNC_LOAD_FACE: begin
                     if ({1'b0, req_item_index} >= nf) begin
                        rsp_st_in = STATUS_INDEX;
                     end else if (({1'b0, req_corner_a} >= nv) ||
                                  ({1'b0, req_corner_b} >= nv) ||
                                  ({1'b0, req_corner_c} >= nv)) begin
                        rsp_st_in = STATUS_CORNER;
                     end else begin
                        fcorn_we = 1'b1;
                        valid_in = 1'b0;
                     end
                  end
                  FUNC_COMPUTE: begin
                     rsp_valid_in = 1'b0;
                     f_in         = '0;
                     bad_in       = 1'b0;
                     state_in     = S_C_CORN;
                  end
                  FUNC_READ_FACE: begin
                     if ({1'b0, req_item_index} >= nf) begin
                        rsp_st_in = STATUS_INDEX;
                     end else if (valid_ff) begin
                        rsp_valid_in = 1'b0;
                        fnorm_raddr  = req_item_index[FACE_AW-1:0];
                        state_in     = S_F_RD;
                     end
                  end
                  FUNC_READ_VERT: begin
                     if (req_item_index >= nv) begin
                        rsp_st_in = STATUS_INDEX;
                     end else if (valid_ff) begin
                        rsp_valid_in = 1'b0;
                        vsum_raddr   = req_item_index[VERT_AW-1:0];
                        state_in     = S_V_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_F_RD: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = fnorm_rd_ff[47:32];
            rsp_y_in     = fnorm_rd_ff[31:16];
            rsp_z_in     = fnorm_rd_ff[15:0];
            rsp_st_in    = STATUS_OK;
            state_in     = S_IDLE;
         end
         S_V_RD: begin
            norm_start = 1'b1;
            norm_vec.x = WIDE_W'(sumv[0]);
            norm_vec.y = WIDE_W'(sumv[1]);
            norm_vec.z = WIDE_W'(sumv[2]);
            state_in   = S_V_NORM;
         end
         S_V_NORM: begin
            if (norm_done) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = norm_res.x;
               rsp_y_in     = norm_res.y;
               rsp_z_in     = norm_res.z;
               rsp_st_in    = STATUS_OK;
               state_in     = S_IDLE;
            end
         end
         S_C_CORN: begin
            if (f_ff == nf) begin
               v_in     = '0;
               state_in = S_CLR;
            end else begin
               state_in = S_C_CHK;
            end
         end
         S_C_CHK: begin
            if (corner_bad) begin
               fnorm_we    = 1'b1;
               fnorm_wdata = '0;
               bad_in      = 1'b1;
               f_in        = f_ff + 12'd1;
               state_in    = S_C_CORN;
            end else begin
               cn_in[0] = ca;
               cn_in[1] = cb;
               cn_in[2] = cc;
               state_in = S_C_VA;
            end
         end
         S_C_VA: begin
            pa_in      = vpos_rd_ff;
            vpos_raddr = cn_ff[1];
            state_in   = S_C_VB;
         end
         S_C_VB: begin
            for (int i = 0; i < 3; i++) e1_in[i] = 17'(pos[i]) - 17'(pav[i]);
            vpos_raddr = cn_ff[2];
            state_in   = S_C_VC;
         end
         S_C_VC: begin
            for (int i = 0; i < 3; i++) e2_in[i] = 17'(pos[i]) - 17'(pav[i]);
            step_in  = 3'd0;
            state_in = S_C_CROSS;
         end
         S_C_CROSS: begin
            if (!step_ff[0]) acc_in = prod;
            else cr_in[step_ff[2:1]] = 35'(acc_ff) - 35'(prod);
            if (step_ff == 3'd5) state_in = S_C_START;
            else step_in = step_ff + 3'd1;
         end
         S_C_START: begin
            norm_start = 1'b1;
            state_in   = S_C_NORM;
         end
         S_C_NORM: begin
            if (norm_done) begin
               fnorm_we = 1'b1;
               f_in     = f_ff + 12'd1;
               state_in = S_C_CORN;
            end
         end
         S_CLR: begin
            if (v_ff == nv) begin
               f_in     = '0;
               state_in = S_A_CORN;
            end else begin
               vsum_we    = 1'b1;
               vsum_waddr = v_ff[VERT_AW-1:0];
               vsum_wdata = '0;
               v_in       = v_ff + 11'd1;
            end
         end
         S_A_CORN: begin
            if (f_ff == nf) begin
               valid_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_z_in     = '0;
               rsp_st_in    = bad_ff ? STATUS_CORNER : STATUS_OK;
               state_in     = S_IDLE;
            end else begin
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (corner_bad) begin
               f_in     = f_ff + 12'd1;
               state_in = S_A_CORN;
            end else begin
               cn_in[0] = ca;
               cn_in[1] = cb;
               cn_in[2] = cc;
               state_in = S_A_FN;
            end
         end
         S_A_FN: begin
            fn_in    = fnorm_rd_ff;
            k_in     = 2'd0;
            state_in = S_A_RD;
         end
         S_A_RD: begin
            state_in = S_A_RMW;
         end
         S_A_RMW: begin
            vsum_we = 1'b1;
            if (k_ff == 2'd2) begin
               f_in     = f_ff + 12'd1;
               state_in = S_A_CORN;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_A_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         valid_in = 1'b0;
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wdata[10:0];
            CSR_FACE_COUNT:   fcount_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= '0;
         fcount_ff    <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         fcount_ff    <= fcount_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bad_ff    <= bad_in;
      f_ff      <= f_in;
      v_ff      <= v_in;
      k_ff      <= k_in;
      step_ff   <= step_in;
      pa_ff     <= pa_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      acc_ff    <= acc_in;
      cr_ff     <= cr_in;
      cn_ff     <= cn_in;
      fn_ff     <= fn_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_z_ff  <= rsp_z_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_norm_x = rsp_x_ff;
   assign rsp_norm_y = rsp_y_ff;
   assign rsp_norm_z = rsp_z_ff;
   assign rsp_status = rsp_st_ff;

endmodule
